FILE: hw/rtl/dqc_pkg.sv
// shared types and constants for the double-ended queue with cursor
// used by dqc_core and deque_with_cursor_top; depends on nothing
`default_nettype none

package dqc_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	// fixed field widths on the stream ports
	localparam int OP_W    = 3;
	localparam int FIELD_W = 32;
	localparam int COUNT_W = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 136;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_CUR_START  = 3'd4;
	localparam logic [OP_W-1:0] OP_CUR_NEXT   = 3'd5;
	localparam logic [OP_W-1:0] OP_CUR_END    = 3'd6;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd7;

	// per-operation outcome, known in the cycle the beat is taken
	typedef struct packed {
		logic [FIELD_W-1:0] item_out;
		logic               found;
		logic               full_drop;
		logic               use_cur;
		logic               cur_valid;
		logic               nonempty;
		logic [COUNT_W-1:0] count;
	} step_t;

	// front, back and cursor items as they stand now
	typedef struct packed {
		logic [FIELD_W-1:0] first;
		logic [FIELD_W-1:0] last;
		logic [FIELD_W-1:0] current;
	} view_t;

endpackage

`default_nettype wire

FILE: hw/rtl/deque_with_cursor_top.sv
// top level of the double-ended queue with cursor: stream ports and result pipeline
// instantiates dqc_core; uses dqc_pkg
//
// Bounded double-ended queue of item handles in a ring of DEPTH slots, with one
// iteration cursor. Each input beat carries one operation (push or pop at either
// end, cursor start, next or end, or query) and yields exactly one result beat
// with the popped or current item, found and full_drop flags, the entry count and
// the front, back and cursor items after the operation. One beat is taken every
// cycle unless m_tready stalls the result; each result is registered in stage
// one and then in the output register. The item memory has a single port and every
// operation needs at most one access to it: pushes write, pops and cursor next read
// the neighbouring slot, and the read data is registered on its way to the result.
// Items beyond 32 bits are cut to 32 on the result port. A push into a full queue
// is dropped and flagged; pops on an empty queue return zero with found low.
`default_nettype none

module deque_with_cursor_top #(
	parameter int DEPTH      = dqc_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = dqc_pkg::ITEM_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// op [2:0], item_in [34:3], zero [39:35]
	input  wire logic [dqc_pkg::S_TDATA_W-1:0]  s_tdata,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// item_out [31:0], found [32], full_drop [33], entry_count [38:34],
	// first_item [70:39], last_item [102:71], current_item [134:103],
	// current_valid [135]
	output      logic [dqc_pkg::M_TDATA_W-1:0]  m_tdata
);

	dqc_pkg::step_t step, step_s1;
	dqc_pkg::view_t view;

	logic                            take, v_s1, adv_s1, m_valid_q;
	logic [dqc_pkg::M_TDATA_W-1:0]   m_data_q;
	logic [dqc_pkg::FIELD_W-1:0]     item_out, first, last, current;

	// take a beat when stage one is empty or moves on
	assign adv_s1   = v_s1 && (!m_valid_q || m_tready);
	assign s_tready = !v_s1 || adv_s1;
	assign take     = s_tvalid && s_tready;

	dqc_core #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.op     (s_tdata[2:0]),
		.item   (s_tdata[34:3]),
		.step   (step),
		.view   (view)
	);

	// stage one holds the outcome while the item copies settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) step_s1 <= step;
	end

	// result fields; copies are meaningful only when their entry exists
	assign current  = step_s1.cur_valid ? view.current : '0;
	assign first    = step_s1.nonempty ? view.first : '0;
	assign last     = step_s1.nonempty ? view.last : '0;
	assign item_out = step_s1.use_cur ? current : step_s1.item_out;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_data_q <= {step_s1.cur_valid, current, last, first, step_s1.count,
				step_s1.full_drop, step_s1.found, item_out};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dqc_core.sv
// ring storage, pointers and cursor of the double-ended queue
// holds the item memory plus front, back and cursor item copies; uses dqc_pkg
`default_nettype none

module dqc_core #(
	parameter int DEPTH      = dqc_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = dqc_pkg::ITEM_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic [dqc_pkg::OP_W-1:0]     op,
	input  wire logic [dqc_pkg::FIELD_W-1:0]  item,
	output dqc_pkg::step_t                    step,
	output dqc_pkg::view_t                    view
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// which item copy waits on the memory read data
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_FRONT = 2'd1;
	localparam logic [1:0] PEND_BACK  = 2'd2;
	localparam logic [1:0] PEND_CUR   = 2'd3;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
	endfunction

	logic [ITEM_WIDTH-1:0] mem [DEPTH];
	logic [ITEM_WIDTH-1:0] rd_q;

	logic [AW-1:0]         front_q, back_q, cur_slot_q;
	logic [CW-1:0]         count_q;
	logic                  cur_set_q;
	logic [1:0]            pend_q;
	logic [ITEM_WIDTH-1:0] fv_q, bv_q, cv_q;

	logic [AW-1:0]         front_n, back_n, cur_slot_n;
	logic [CW-1:0]         count_n;
	logic                  cur_set_n;
	logic [1:0]            pend_n;
	logic [ITEM_WIDTH-1:0] fv_n, bv_n, cv_n;
	logic [ITEM_WIDTH-1:0] fv, bv, cv, item_w, pop_val;

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic                  full, empty, drop, popped, cur_op;

	// copies forwarded from the read data while they are still pending
	assign fv     = (pend_q == PEND_FRONT) ? rd_q : fv_q;
	assign bv     = (pend_q == PEND_BACK)  ? rd_q : bv_q;
	assign cv     = (pend_q == PEND_CUR)   ? rd_q : cv_q;
	assign item_w = ITEM_WIDTH'(item);
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	// one operation per beat: at most one memory write or one memory read
	always_comb begin
		front_n    = front_q;
		back_n     = back_q;
		count_n    = count_q;
		cur_slot_n = cur_slot_q;
		cur_set_n  = cur_set_q;
		fv_n       = fv;
		bv_n       = bv;
		cv_n       = cv;
		pend_n     = PEND_NONE;
		wr_en      = 1'b0;
		wr_addr    = slot_inc(back_q);
		rd_en      = 1'b0;
		rd_addr    = slot_dec(back_q);
		drop       = 1'b0;
		popped     = 1'b0;
		pop_val    = '0;
		cur_op     = 1'b0;
		if (take) begin
			unique case (op)
				dqc_pkg::OP_PUSH_BACK: begin
					if (full) begin
						drop = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_addr = slot_inc(back_q);
						back_n  = slot_inc(back_q);
						count_n = count_q + CW'(1);
						bv_n    = item_w;
						if (empty) fv_n = item_w;
					end
				end
				dqc_pkg::OP_PUSH_FRONT: begin
					if (full) begin
						drop = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_addr = slot_dec(front_q);
						front_n = slot_dec(front_q);
						count_n = count_q + CW'(1);
						fv_n    = item_w;
						if (empty) bv_n = item_w;
					end
				end
				dqc_pkg::OP_POP_BACK: begin
					if (!empty) begin
						popped  = 1'b1;
						pop_val = bv;
						back_n  = slot_dec(back_q);
						count_n = count_q - CW'(1);
						if (cur_set_q && cur_slot_q == back_q) begin
							cur_set_n  = 1'b0;
							cur_slot_n = '0;
						end
						// fetch the new back item
						if (count_q != CW'(1)) begin
							rd_en   = 1'b1;
							rd_addr = slot_dec(back_q);
							pend_n  = PEND_BACK;
						end
					end
				end
				dqc_pkg::OP_POP_FRONT: begin
					if (!empty) begin
						popped  = 1'b1;
						pop_val = fv;
						front_n = slot_inc(front_q);
						count_n = count_q - CW'(1);
						if (cur_set_q && cur_slot_q == front_q) begin
							cur_set_n  = 1'b0;
							cur_slot_n = '0;
						end
						// fetch the new front item
						if (count_q != CW'(1)) begin
							rd_en   = 1'b1;
							rd_addr = slot_inc(front_q);
							pend_n  = PEND_FRONT;
						end
					end
				end
				dqc_pkg::OP_CUR_START: begin
					cur_op     = 1'b1;
					cur_set_n  = !empty;
					cur_slot_n = empty ? '0 : front_q;
					cv_n       = fv;
				end
				dqc_pkg::OP_CUR_NEXT: begin
					cur_op = 1'b1;
					if (!cur_set_q) begin
						cur_set_n  = !empty;
						cur_slot_n = empty ? '0 : front_q;
						cv_n       = fv;
					end else if (cur_slot_q == back_q) begin
						cur_set_n  = 1'b0;
						cur_slot_n = '0;
					end else begin
						cur_slot_n = slot_inc(cur_slot_q);
						rd_en      = 1'b1;
						rd_addr    = slot_inc(cur_slot_q);
						pend_n     = PEND_CUR;
					end
				end
				dqc_pkg::OP_CUR_END: begin
					cur_op     = 1'b1;
					cur_set_n  = !empty;
					cur_slot_n = empty ? '0 : back_q;
					cv_n       = bv;
				end
				default: begin
				end
			endcase
		end
	end

	// outcome of this beat
	always_comb begin
		step           = '0;
		step.item_out  = dqc_pkg::FIELD_W'(pop_val);
		step.found     = cur_op ? cur_set_n : popped;
		step.full_drop = drop;
		step.use_cur   = cur_op;
		step.cur_valid = cur_set_n;
		step.nonempty  = (count_n != '0);
		step.count     = dqc_pkg::COUNT_W'(count_n);
	end

	assign view.first   = dqc_pkg::FIELD_W'(fv);
	assign view.last    = dqc_pkg::FIELD_W'(bv);
	assign view.current = dqc_pkg::FIELD_W'(cv);

	// item memory, one access a cycle, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= item_w;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// pointers, count and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			back_q     <= AW'(DEPTH - 1);
			count_q    <= '0;
			cur_slot_q <= '0;
			cur_set_q  <= 1'b0;
			pend_q     <= PEND_NONE;
		end else begin
			front_q    <= front_n;
			back_q     <= back_n;
			count_q    <= count_n;
			cur_slot_q <= cur_slot_n;
			cur_set_q  <= cur_set_n;
			pend_q     <= pend_n;
		end
	end

	// item copies at front, back and cursor
	always_ff @(posedge clk) begin
		fv_q <= fv_n;
		bv_q <= bv_n;
		cv_q <= cv_n;
	end

endmodule

`default_nettype wire
